>>> rtl/mtp_pkg.sv
`timescale 1ns / 1ps

package mtp_pkg;

   // Token kinds that the front end hands to the back end.
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_SPACE = 3'd1;
   localparam logic [2:0] KIND_DIGIT = 3'd2;
   localparam logic [2:0] KIND_SEP   = 3'd3;
   localparam logic [2:0] KIND_BAD   = 3'd4;

   // Separator codes.
   localparam logic [1:0] SEP_NONE  = 2'd0;
   localparam logic [1:0] SEP_COLON = 2'd1;
   localparam logic [1:0] SEP_DASH  = 2'd2;
   localparam logic [1:0] SEP_DOT   = 2'd3;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NBSP  = 8'hA0;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;

   // Digit and group length constants, all at the 5-bit counter width.
   localparam int         LEN_W          = 5;
   localparam logic [4:0] DIGITS_FULL    = 5'd16;
   localparam logic [4:0] DIGITS_SHORT   = 5'd12;
   localparam logic [4:0] GROUP_LEN_TWO  = 5'd2;
   localparam logic [4:0] GROUP_LEN_FOUR = 5'd4;
   localparam logic [4:0] GROUP_LEN_LONG = 5'd6;

   localparam logic [7:0] EUI_FILL_HI = 8'hFF;
   localparam logic [7:0] EUI_FILL_LO = 8'hFE;

   // Depth of the token queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] nibble;
      logic [1:0] sep;
      logic       last;
   } token_type;

   function automatic token_type classify(input logic [7:0] c, input logic no_char,
                                          input logic last);
      token_type t;
      t.kind   = KIND_BAD;
      t.nibble = 4'd0;
      t.sep    = SEP_NONE;
      t.last   = last;
      if (no_char) begin
         t.kind = KIND_NONE;
      end else if ((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE || c == CHAR_NBSP) begin
         t.kind = KIND_SPACE;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         t.kind   = KIND_DIGIT;
         t.nibble = c[3:0];
      end else if ((c >= CHAR_LOW_A && c <= CHAR_LOW_F) || (c >= CHAR_UP_A && c <= CHAR_UP_F)) begin
         // Both letter ranges start at an offset of one in the low nibble.
         t.kind   = KIND_DIGIT;
         t.nibble = c[3:0] + 4'd9;
      end else if (c == CHAR_COLON) begin
         t.kind = KIND_SEP;
         t.sep  = SEP_COLON;
      end else if (c == CHAR_DASH) begin
         t.kind = KIND_SEP;
         t.sep  = SEP_DASH;
      end else if (c == CHAR_DOT) begin
         t.kind = KIND_SEP;
         t.sep  = SEP_DOT;
      end
      return t;
   endfunction

endpackage

>>> rtl/mtp_if.sv
`timescale 1ns / 1ps

interface mtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       is_last;
   logic       no_char;

   modport source (output valid, output character, output is_last, output no_char,
                   input ready);
   modport sink (input valid, input character, input is_last, input no_char,
                 output ready);
endinterface

interface mtp_rsp_if;
   logic        valid;
   logic        ready;
   logic        parse_error;
   logic [63:0] address;

   modport source (output valid, output parse_error, output address, input ready);
   modport sink (input valid, input parse_error, input address, output ready);
endinterface

>>> rtl/mtp_front.sv
`timescale 1ns / 1ps

module mtp_front (
   mtp_req_if.sink             req,
   input  logic                queue_full,
   output logic                push,
   output mtp_pkg::token_type  push_token
);

   assign req.ready  = !queue_full;
   assign push       = req.valid && !queue_full;
   assign push_token = mtp_pkg::classify(req.character, req.no_char, req.is_last);

endmodule

>>> rtl/mtp_queue.sv
`timescale 1ns / 1ps

module mtp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mtp_pkg::token_type  push_token,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output mtp_pkg::token_type  pop_token
);

   localparam int PW = mtp_pkg::QPTR_W;
   localparam int CW = mtp_pkg::QCNT_W;

   mtp_pkg::token_type entry_ff [mtp_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == CW'(mtp_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

>>> rtl/mtp_back.sv
`timescale 1ns / 1ps

module mtp_back #(
   parameter int MAX_GROUPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                eight_byte_mode,
   input  logic                tok_valid,
   input  mtp_pkg::token_type  tok,
   output logic                pop,
   mtp_rsp_if.source           rsp
);

   localparam int GW = $clog2(MAX_GROUPS + 1);
   localparam logic [GW-1:0] GROUPS_MAX = GW'(MAX_GROUPS);
   localparam logic [GW-1:0] GROUPS_TWO = GW'(2);
   localparam int LW = mtp_pkg::LEN_W;

   logic [63:0]   shift_ff, shift_in;
   logic [LW-1:0] count_ff, count_in;
   logic [1:0]    sep_ff, sep_in;
   logic [GW-1:0] groups_ff, groups_in;
   logic [LW-1:0] cur_len_ff, cur_len_in;
   logic [LW-1:0] first_len_ff, first_len_in;
   logic          all_four_ff, all_four_in;
   logic          all_two_ff, all_two_in;
   logic          error_ff, error_in;
   logic          started_ff, started_in;
   logic          trailing_ff, trailing_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_error_ff;
   logic [63:0]   rsp_addr_ff;

   logic          bad;
   logic          fin_four, fin_two;
   logic [LW-1:0] fin_first_len;
   logic [GW-1:0] fin_groups;
   logic [63:0]   fin_addr;

   // A last token needs the output register free; others always go.
   assign pop = tok_valid && (!tok.last || !rsp_valid_ff || rsp.ready);

   always_comb begin
      shift_in     = shift_ff;
      count_in     = count_ff;
      sep_in       = sep_ff;
      groups_in    = groups_ff;
      cur_len_in   = cur_len_ff;
      first_len_in = first_len_ff;
      all_four_in  = all_four_ff;
      all_two_in   = all_two_ff;
      error_in     = error_ff;
      started_in   = started_ff;
      trailing_in  = trailing_ff;

      if (tok.kind != mtp_pkg::KIND_NONE && !error_ff) begin
         if (tok.kind == mtp_pkg::KIND_SPACE) begin
            if (started_ff) begin
               trailing_in = 1'b1;
            end
         end else if (trailing_ff) begin
            error_in = 1'b1;
         end else begin
            started_in = 1'b1;
            case (tok.kind)
               mtp_pkg::KIND_DIGIT: begin
                  if (count_ff >= mtp_pkg::DIGITS_FULL) begin
                     error_in = 1'b1;
                  end else begin
                     shift_in   = {shift_ff[59:0], tok.nibble};
                     count_in   = count_ff + LW'(1);
                     cur_len_in = cur_len_ff + LW'(1);
                  end
               end
               mtp_pkg::KIND_SEP: begin
                  if (sep_ff != mtp_pkg::SEP_NONE && sep_ff != tok.sep) begin
                     error_in = 1'b1;
                  end else begin
                     sep_in = tok.sep;
                     if (groups_ff >= GROUPS_MAX) begin
                        error_in = 1'b1;
                     end else begin
                        if (groups_ff == '0) begin
                           first_len_in = cur_len_ff;
                        end
                        all_four_in = all_four_ff && cur_len_ff == mtp_pkg::GROUP_LEN_FOUR;
                        all_two_in  = all_two_ff && cur_len_ff == mtp_pkg::GROUP_LEN_TWO;
                        groups_in   = groups_ff + GW'(1);
                        cur_len_in  = '0;
                     end
                  end
               end
               default: begin
                  error_in = 1'b1;
               end
            endcase
         end
      end
   end

   // End of string: close the open group, check the whole shape and form the address.
   always_comb begin
      fin_four      = all_four_in && cur_len_in == mtp_pkg::GROUP_LEN_FOUR;
      fin_two       = all_two_in && cur_len_in == mtp_pkg::GROUP_LEN_TWO;
      fin_first_len = (groups_in == '0) ? cur_len_in : first_len_in;
      fin_groups    = groups_in + GW'(1);

      bad = error_in || groups_in >= GROUPS_MAX;
      if (eight_byte_mode) begin
         if (count_in != mtp_pkg::DIGITS_FULL && count_in != mtp_pkg::DIGITS_SHORT) begin
            bad = 1'b1;
         end
      end else if (count_in != mtp_pkg::DIGITS_SHORT) begin
         bad = 1'b1;
      end
      if (sep_in == mtp_pkg::SEP_DOT) begin
         if (!fin_four) begin
            bad = 1'b1;
         end
      end else if (sep_in != mtp_pkg::SEP_NONE) begin
         if (!fin_two && !(fin_groups == GROUPS_TWO
                           && fin_first_len == mtp_pkg::GROUP_LEN_LONG)) begin
            bad = 1'b1;
         end
      end

      if (bad) begin
         fin_addr = '0;
      end else if (eight_byte_mode && count_in == mtp_pkg::DIGITS_SHORT) begin
         fin_addr = {shift_in[47:24], mtp_pkg::EUI_FILL_HI, mtp_pkg::EUI_FILL_LO,
                     shift_in[23:0]};
      end else begin
         fin_addr = shift_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (pop && tok.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (pop && tok.last)) begin
         shift_ff     <= '0;
         count_ff     <= '0;
         sep_ff       <= mtp_pkg::SEP_NONE;
         groups_ff    <= '0;
         cur_len_ff   <= '0;
         first_len_ff <= '0;
         all_four_ff  <= 1'b1;
         all_two_ff   <= 1'b1;
         error_ff     <= 1'b0;
         started_ff   <= 1'b0;
         trailing_ff  <= 1'b0;
      end else if (pop) begin
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         sep_ff       <= sep_in;
         groups_ff    <= groups_in;
         cur_len_ff   <= cur_len_in;
         first_len_ff <= first_len_in;
         all_four_ff  <= all_four_in;
         all_two_ff   <= all_two_in;
         error_ff     <= error_in;
         started_ff   <= started_in;
         trailing_ff  <= trailing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && tok.last) begin
         rsp_error_ff <= bad;
         rsp_addr_ff  <= fin_addr;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.parse_error = rsp_error_ff;
   assign rsp.address     = rsp_addr_ff;

endmodule

>>> rtl/mac_address_text_parser.sv
`timescale 1ns / 1ps

// Channel    Dir  Handshake          Payload
// req_chan   in   valid / ready      character[7:0], is_last, no_char
// rsp_chan   out  valid / ready      parse_error, address[63:0]
// csr        in   csr_valid / ready  csr_eight_byte_mode
//
// One character is taken per cycle while the token queue is not full; a string's last token
// passes the queue and the output register; the back-end update on each pop sets the rate.
// Reset is synchronous and empties the token queue and the output register.
// A full output register stalls only the last token of a string; while it waits at the
// head of the two-entry queue, one more request is taken before ready drops.
module mac_address_text_parser #(
   parameter int MAX_GROUPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   mtp_req_if.sink     req_chan,
   mtp_rsp_if.source   rsp_chan,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_eight_byte_mode
);

   logic               mode_ff;
   logic               queue_full;
   logic               push;
   mtp_pkg::token_type push_token;
   logic               pop;
   logic               tok_valid;
   mtp_pkg::token_type tok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_eight_byte_mode;
      end
   end

   mtp_front u_front (
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_token (push_token)
   );

   mtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (tok_valid),
      .pop_token  (tok)
   );

   mtp_back #(
      .MAX_GROUPS (MAX_GROUPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .eight_byte_mode (mode_ff),
      .tok_valid       (tok_valid),
      .tok             (tok),
      .pop             (pop),
      .rsp             (rsp_chan)
   );

endmodule

>>> rtl/mtp_checker.sv
`timescale 1ns / 1ps

module mtp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_parse_error,
   input logic [63:0] rsp_address
);

   // A rejected string never carries address bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_error |-> rsp_address == 64'd0)
      else $error("rejected string with nonzero address");

   // The output register is cleared by reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_parse_error)
                                  && $stable(rsp_address))
      else $error("stalled response changed");

endmodule

bind mac_address_text_parser mtp_checker u_mtp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_parse_error (rsp_chan.parse_error),
   .rsp_address     (rsp_chan.address)
);
